>>> rtl/core/srw_pkg.sv
// ----------------------------------------------------------------------------
// srw_pkg
// shared types and constants of the sequence reorder window
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SZ_W   = SLOT_W + 1;

    localparam int SEQ_W  = 64;
    localparam int VAL_W  = 64;
    localparam int WS_W   = 7;
    localparam int CIDX_W = 8;
    localparam int CDAT_W = 64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CIDX_W-1:0] REG_WINDOW_SIZE    = 8'd0;
    localparam logic [CIDX_W-1:0] REG_FIRST_SEQUENCE = 8'd1;

    localparam logic [WS_W-1:0]  RST_WINDOW_SIZE    = 7'd64;
    localparam logic [SEQ_W-1:0] RST_FIRST_SEQUENCE = 64'd0;

    typedef struct packed {
        logic             operation;
        logic [SEQ_W-1:0] sequence_req;
        logic [VAL_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic             done_res;
        logic [VAL_W-1:0] read_value;
        logic [SEQ_W-1:0] read_sequence;
        logic             head_ready;
        logic [SEQ_W-1:0] next_sequence;
    } t_res_item;

endpackage

>>> rtl/core/srw_ram.sv
// ----------------------------------------------------------------------------
// srw_ram
// generic single-clock ram, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module srw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sequence_reorder_window.sv
// ----------------------------------------------------------------------------
// sequence_reorder_window
// reorder window keyed by sequence number, payloads held in a ring ram
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output is not stalled; each result
// passes the registered read of the slot ram, beside the pending register,
// then the output register. Payloads live in the ram; a flag per slot
// (nonzero payload) sits in flip-flops, so reset or a configuration write
// empties the window with no clearing pass. Configuration writes are always
// taken and must only come while no item is in flight.
module sequence_reorder_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  srw_pkg::t_in_item            i_in_data,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output srw_pkg::t_res_item           o_res_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [srw_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [srw_pkg::CDAT_W-1:0]   i_cfg_data
);

    logic [srw_pkg::WS_W-1:0]   r_ws;
    logic [srw_pkg::SEQ_W-1:0]  r_first;
    logic [srw_pkg::SEQ_W-1:0]  r_base,  n_base;
    logic [srw_pkg::SLOT_W-1:0] r_head,  n_head;
    logic [srw_pkg::SLOTS-1:0]  r_nz,    n_nz;

    logic               r_p_valid;
    logic               r_p_pop;
    srw_pkg::t_res_item r_p_res, n_p_res;
    logic               r_o_valid;
    srw_pkg::t_res_item r_o_res, n_o_res;

    logic [srw_pkg::SZ_W-1:0]   size;
    logic [srw_pkg::SLOT_W-1:0] h;
    logic [srw_pkg::SEQ_W-1:0]  off;
    logic                       in_win;
    logic [srw_pkg::SZ_W-1:0]   idx_sum;
    logic [srw_pkg::SZ_W-1:0]   h_inc;
    logic [srw_pkg::SLOT_W-1:0] widx;
    logic                       pop;
    logic                       accept;
    logic                       move;
    logic                       cfg_hit;
    logic                       ram_we;
    logic                       ram_re;
    logic [srw_pkg::VAL_W-1:0]  ram_q;

    assign move        = r_p_valid && (!r_o_valid || i_res_ready);
    assign o_in_ready  = !r_p_valid || move;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && ((i_cfg_index == srw_pkg::REG_WINDOW_SIZE) ||
                                         (i_cfg_index == srw_pkg::REG_FIRST_SEQUENCE));

    // effective window size and head
    always_comb begin
        if (r_ws == '0) begin
            size = srw_pkg::SZ_W'(1);
        end else if (64'(r_ws) > 64'(srw_pkg::SLOTS)) begin
            size = srw_pkg::SZ_W'(srw_pkg::SLOTS);
        end else begin
            size = srw_pkg::SZ_W'(r_ws);
        end
        if ({1'b0, r_head} >= size) begin
            h = '0;
        end else begin
            h = r_head;
        end
    end

    always_comb begin
        off     = i_in_data.sequence_req - r_base;
        in_win  = off < 64'(size);
        idx_sum = srw_pkg::SZ_W'(off) + {1'b0, h};
        if (idx_sum >= size) begin
            idx_sum = idx_sum - size;
        end
        widx  = idx_sum[srw_pkg::SLOT_W-1:0];
        pop   = (i_in_data.operation == srw_pkg::OP_READ) && r_nz[h];
        h_inc = {1'b0, h} + srw_pkg::SZ_W'(1);
        if (h_inc >= size) begin
            h_inc = '0;
        end

        n_nz   = r_nz;
        n_base = r_base;
        n_head = h;
        n_p_res = '0;
        if (i_in_data.operation == srw_pkg::OP_WRITE) begin
            if (in_win) begin
                n_nz[widx] = (i_in_data.write_value != '0);
                n_p_res.done_res = 1'b1;
            end
        end else if (pop) begin
            n_nz[h] = 1'b0;
            n_base  = r_base + 64'd1;
            n_head  = h_inc[srw_pkg::SLOT_W-1:0];
            n_p_res.done_res      = 1'b1;
            n_p_res.read_sequence = r_base;
        end
        n_p_res.head_ready    = n_nz[n_head];
        n_p_res.next_sequence = n_base;
    end

    assign ram_we = accept && (i_in_data.operation == srw_pkg::OP_WRITE) && in_win;
    assign ram_re = accept && pop;

    srw_ram #(
        .WIDTH (srw_pkg::VAL_W),
        .DEPTH (srw_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx),
        .i_wdata (i_in_data.write_value),
        .i_re    (ram_re),
        .i_raddr (h),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= srw_pkg::RST_WINDOW_SIZE;
            r_first   <= srw_pkg::RST_FIRST_SEQUENCE;
            r_base    <= srw_pkg::RST_FIRST_SEQUENCE;
            r_head    <= '0;
            r_nz      <= '0;
            r_p_valid <= 1'b0;
            r_p_pop   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (cfg_hit) begin
                r_nz   <= '0;
                r_head <= '0;
                if (i_cfg_index == srw_pkg::REG_WINDOW_SIZE) begin
                    r_ws   <= i_cfg_data[srw_pkg::WS_W-1:0];
                    r_base <= r_first;
                end else begin
                    r_first <= i_cfg_data;
                    r_base  <= i_cfg_data;
                end
            end else if (accept) begin
                r_nz   <= n_nz;
                r_head <= n_head;
                r_base <= n_base;
            end

            if (accept) begin
                r_p_valid <= 1'b1;
                r_p_pop   <= pop;
            end else if (move) begin
                r_p_valid <= 1'b0;
            end

            if (move) begin
                r_o_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // pending result with the payload read from the ram
    always_comb begin
        n_o_res            = r_p_res;
        n_o_res.read_value = r_p_pop ? ram_q : '0;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_res <= n_p_res;
        end
        if (move) begin
            r_o_res <= n_o_res;
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_res_data  = r_o_res;

    // head never leaves the active window
    a_head_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < size)
        else $error("head index outside active window");

    // a pop moves the base by exactly one
    a_pop_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && pop && !cfg_hit |=> r_base == $past(r_base) + 64'd1)
        else $error("base not advanced on pop");

    // popped slot is empty afterwards
    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && pop && !cfg_hit |=> !r_nz[$past(h)])
        else $error("popped slot still marked full");

    // a pending pop always reports done
    a_pop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid && r_p_pop |-> r_p_res.done_res)
        else $error("pop without done");

    // an accepted item reaches the pending stage
    a_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_p_valid)
        else $error("accepted item lost");

endmodule
